FILE: rtl/sugs_pkg.sv
// Package for the Sobel unit-gradient block.
// Holds sizes, register indexes, controller states and command/status types.
// No dependencies.
package sugs_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int FRAC_BITS  = 14;
  localparam int MIN_SIDE   = 3;
  localparam int THR_SHIFT  = 6;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WID_W    = 12;
  localparam int HGT_W    = 13;
  localparam int PIX_W    = 8;
  localparam int G_W      = 11;
  localparam int SQ_W     = 20;
  localparam int S_W      = 21;
  localparam int THR_W    = 22;
  localparam int T_W      = FRAC_BITS + 2;
  localparam int OSQ_W    = 2 * T_W;
  localparam int PROD_W   = OSQ_W + S_W;
  localparam int BIT_W    = $clog2(FRAC_BITS + 1);
  localparam int UNIT_W   = 16;
  localparam int OUT_ROW_W = 12;
  localparam int OUT_COL_W = 11;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_W        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_H        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONTRAST = 3'd6;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_GRAD  = 9'b000000010,
    ST_SQ    = 9'b000000100,
    ST_SUM   = 9'b000001000,
    ST_CHECK = 9'b000010000,
    ST_BSQ   = 9'b000100000,
    ST_BMUL  = 9'b001000000,
    ST_BCMP  = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic accept;
    logic grad;
    logic square;
    logic sum;
    logic bit_sq;
    logic bit_mul;
    logic bit_cmp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic calc;
    logic last_bit;
    logic last_comp;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/sugs_if.sv
// Stream interfaces for the Sobel unit-gradient block: pixel requests in,
// gradient results out. Depends on sugs_pkg.
interface sugs_pix_if;
  logic                       valid;
  logic                       ready;
  logic [sugs_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface sugs_res_if;
  logic                           valid;
  logic                           ready;
  logic [sugs_pkg::UNIT_W-1:0]    unit_gx;
  logic [sugs_pkg::UNIT_W-1:0]    unit_gy;
  logic [sugs_pkg::OUT_ROW_W-1:0] out_row;
  logic [sugs_pkg::OUT_COL_W-1:0] out_col;
  logic                           frame_last;
  modport source (output valid, output unit_gx, output unit_gy, output out_row,
                  output out_col, output frame_last, input ready);
  modport sink (input valid, input unit_gx, input unit_gy, input out_row,
                input out_col, input frame_last, output ready);
endinterface

FILE: rtl/sugs_ctrl.sv
// Controller state machine of the Sobel unit-gradient block.
// Sequences accept, gradient, squaring, bit-serial root division and emit.
// Depends on sugs_pkg.
module sugs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  sugs_pkg::status_t status_i,
  output sugs_pkg::cmd_t    cmd_o,
  output logic              in_ready_o
);

  sugs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sugs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sugs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sugs_pkg::ST_GRAD;
        end
      end
      sugs_pkg::ST_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d    = status_i.has_result ? sugs_pkg::ST_SQ : sugs_pkg::ST_IDLE;
      end
      sugs_pkg::ST_SQ: begin
        cmd_o.square = 1'b1;
        state_d      = sugs_pkg::ST_SUM;
      end
      sugs_pkg::ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = sugs_pkg::ST_CHECK;
      end
      sugs_pkg::ST_CHECK: begin
        state_d = status_i.calc ? sugs_pkg::ST_BSQ : sugs_pkg::ST_EMIT;
      end
      sugs_pkg::ST_BSQ: begin
        cmd_o.bit_sq = 1'b1;
        state_d      = sugs_pkg::ST_BMUL;
      end
      sugs_pkg::ST_BMUL: begin
        cmd_o.bit_mul = 1'b1;
        state_d       = sugs_pkg::ST_BCMP;
      end
      sugs_pkg::ST_BCMP: begin
        cmd_o.bit_cmp = 1'b1;
        if (status_i.last_bit && status_i.last_comp) begin
          state_d = sugs_pkg::ST_EMIT;
        end else begin
          state_d = sugs_pkg::ST_BSQ;
        end
      end
      sugs_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sugs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sugs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/sugs_dp.sv
// Datapath of the Sobel unit-gradient block: config registers, line stores,
// window, gradient and root-division arithmetic, result register.
// Depends on sugs_pkg.
module sugs_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sugs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sugs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [sugs_pkg::PIX_W-1:0]       pixel_i,
  input  sugs_pkg::cmd_t                   cmd_i,
  output sugs_pkg::status_t                status_o,
  input  logic                             res_ready_i,
  output logic                             res_valid_o,
  output logic [sugs_pkg::UNIT_W-1:0]      unit_gx_o,
  output logic [sugs_pkg::UNIT_W-1:0]      unit_gy_o,
  output logic [sugs_pkg::OUT_ROW_W-1:0]   out_row_o,
  output logic [sugs_pkg::OUT_COL_W-1:0]   out_col_o,
  output logic                             frame_last_o
);

  localparam int PW = sugs_pkg::PIX_W;
  localparam int GW = sugs_pkg::G_W;

  // configuration
  logic [11:0] img_w_q;
  logic [12:0] img_h_q;
  logic [10:0] roi_x_q;
  logic [11:0] roi_y_q;
  logic [11:0] roi_w_q;
  logic [12:0] roi_h_q;
  logic [7:0]  min_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 12'd640;
      img_h_q <= 13'd480;
      roi_x_q <= '0;
      roi_y_q <= '0;
      roi_w_q <= 12'd2048;
      roi_h_q <= 13'd4096;
      min_c_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sugs_pkg::CFG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[11:0];
        sugs_pkg::CFG_IMAGE_HEIGHT: img_h_q <= cfg_data_i[12:0];
        sugs_pkg::CFG_ROI_X:        roi_x_q <= cfg_data_i[10:0];
        sugs_pkg::CFG_ROI_Y:        roi_y_q <= cfg_data_i[11:0];
        sugs_pkg::CFG_ROI_W:        roi_w_q <= cfg_data_i[11:0];
        sugs_pkg::CFG_ROI_H:        roi_h_q <= cfg_data_i[12:0];
        sugs_pkg::CFG_MIN_CONTRAST: min_c_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [sugs_pkg::WID_W-1:0] w_eff;
  logic [sugs_pkg::HGT_W-1:0] h_eff;

  always_comb begin
    if (img_w_q == '0) begin
      w_eff = sugs_pkg::WID_W'(1);
    end else if (img_w_q > sugs_pkg::WID_W'(sugs_pkg::MAX_WIDTH)) begin
      w_eff = sugs_pkg::WID_W'(sugs_pkg::MAX_WIDTH);
    end else begin
      w_eff = img_w_q;
    end
    if (img_h_q == '0) begin
      h_eff = sugs_pkg::HGT_W'(1);
    end else if (img_h_q > sugs_pkg::HGT_W'(sugs_pkg::MAX_HEIGHT)) begin
      h_eff = sugs_pkg::HGT_W'(sugs_pkg::MAX_HEIGHT);
    end else begin
      h_eff = img_h_q;
    end
  end

  // position counters and pre-wrap on accept
  logic [sugs_pkg::COL_W-1:0] col_q, c_q, c_pre;
  logic [sugs_pkg::ROW_W-1:0] row_q, r_q, r_pre;
  logic [sugs_pkg::ROW_W:0]   r_tmp;
  logic                       col_wrap;

  always_comb begin
    col_wrap = {1'b0, col_q} >= w_eff;
    c_pre    = col_wrap ? '0 : col_q;
    r_tmp    = col_wrap ? {1'b0, row_q} + 1'b1 : {1'b0, row_q};
    r_pre    = (r_tmp >= h_eff) ? '0 : r_tmp[sugs_pkg::ROW_W-1:0];
  end

  logic [sugs_pkg::COL_W:0] col_n;
  logic [sugs_pkg::ROW_W:0] row_n;
  assign col_n = {1'b0, c_q} + 1'b1;
  assign row_n = {1'b0, r_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.grad) begin
      if (col_n >= w_eff) begin
        col_q <= '0;
        row_q <= (row_n >= h_eff) ? '0 : row_n[sugs_pkg::ROW_W-1:0];
      end else begin
        col_q <= col_n[sugs_pkg::COL_W-1:0];
        row_q <= r_q;
      end
    end
  end

  // line stores
  logic [PW-1:0] line_prev  [sugs_pkg::MAX_WIDTH];
  logic [PW-1:0] line_prev2 [sugs_pkg::MAX_WIDTH];
  logic [PW-1:0] top_q, mid_q, pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      top_q <= line_prev2[c_pre];
      mid_q <= line_prev[c_pre];
      pix_q <= pixel_i;
      c_q   <= c_pre;
      r_q   <= r_pre;
    end
    if (cmd_i.grad) begin
      line_prev2[c_q] <= mid_q;
      line_prev[c_q]  <= pix_q;
    end
  end

  // window
  logic [PW-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.grad) begin
      win_q[0] <= win_q[1];
      win_q[1] <= top_q;
      win_q[2] <= win_q[3];
      win_q[3] <= mid_q;
      win_q[4] <= win_q[5];
      win_q[5] <= pix_q;
    end
  end

  // gradient and region test
  logic signed [GW-1:0] e_top, e_mid, e_bot, e_w0, e_w1, e_w2, e_w4, e_w5;
  logic signed [GW-1:0] gx, gy;
  logic [11:0] rb, re;
  logic [13:0] re_raw;
  logic [10:0] cb;
  logic [12:0] ce, ce_raw;
  logic [11:0] y_c;
  logic [10:0] x_c;
  logic        inroi, has_res;

  always_comb begin
    e_top = $signed({3'b000, top_q});
    e_mid = $signed({3'b000, mid_q});
    e_bot = $signed({3'b000, pix_q});
    e_w0  = $signed({3'b000, win_q[0]});
    e_w1  = $signed({3'b000, win_q[1]});
    e_w2  = $signed({3'b000, win_q[2]});
    e_w4  = $signed({3'b000, win_q[4]});
    e_w5  = $signed({3'b000, win_q[5]});
    gx = (e_top - e_w0) + ((e_mid - e_w2) <<< 1) + (e_bot - e_w4);
    gy = (e_w4 - e_w0) + ((e_w5 - e_w1) <<< 1) + (e_bot - e_top);
    y_c = r_q - 1'b1;
    x_c = c_q - 1'b1;
    rb = (roi_y_q > 12'd1) ? roi_y_q : 12'd1;
    cb = (roi_x_q > 11'd1) ? roi_x_q : 11'd1;
    re_raw = {2'b00, roi_y_q} + {1'b0, roi_h_q};
    re = (re_raw > {1'b0, h_eff - 1'b1}) ? 12'(h_eff - 1'b1) : re_raw[11:0];
    ce_raw = {2'b00, roi_x_q} + {1'b0, roi_w_q};
    ce = (ce_raw > {1'b0, w_eff - 1'b1}) ? {1'b0, w_eff - 1'b1} : ce_raw;
    inroi = (y_c >= rb) && (y_c < re) && (x_c >= cb) && ({2'b00, x_c} < ce);
    has_res = (w_eff >= sugs_pkg::WID_W'(sugs_pkg::MIN_SIDE))
           && (h_eff >= sugs_pkg::HGT_W'(sugs_pkg::MIN_SIDE))
           && (r_q >= 2) && (c_q >= 2);
  end

  logic signed [GW-1:0] gx_q, gy_q;
  logic [11:0] y_q;
  logic [10:0] x_q;
  logic        inroi_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      gx_q    <= gx;
      gy_q    <= gy;
      y_q     <= y_c;
      x_q     <= x_c;
      inroi_q <= inroi;
      last_q  <= ({1'b0, r_q} == h_eff - 1'b1) && ({1'b0, c_q} == w_eff - 1'b1);
    end
  end

  // squares and threshold
  logic [sugs_pkg::SQ_W-1:0]  sxx_q, syy_q;
  logic [sugs_pkg::THR_W-1:0] thr_q;
  logic signed [2*GW-1:0]     px, py;
  logic [15:0]                mc2;

  assign px  = gx_q * gx_q;
  assign py  = gy_q * gy_q;
  assign mc2 = min_c_q * min_c_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sxx_q <= px[sugs_pkg::SQ_W-1:0];
      syy_q <= py[sugs_pkg::SQ_W-1:0];
      thr_q <= sugs_pkg::THR_W'(mc2) << sugs_pkg::THR_SHIFT;
    end
  end

  // root division, one quotient bit per three steps
  logic [sugs_pkg::S_W-1:0]    s, s_q;
  logic                        calc_q, comp_q, tok_q;
  logic [sugs_pkg::BIT_W-1:0]  bit_q;
  logic [sugs_pkg::T_W-1:0]    qx_q, qy_q, q_cur, t;
  logic [sugs_pkg::T_W-1:0]    o;
  logic [sugs_pkg::OSQ_W-1:0]  osq_q;
  logic [sugs_pkg::PROD_W-1:0] prod_q, rhs;
  logic [sugs_pkg::SQ_W-1:0]   asq;

  assign s     = {1'b0, sxx_q} + {1'b0, syy_q};
  assign q_cur = comp_q ? qy_q : qx_q;
  assign t     = q_cur | (sugs_pkg::T_W'(1) << bit_q);
  assign o     = (t << 1) - 1'b1;
  assign asq   = comp_q ? syy_q : sxx_q;
  assign rhs   = sugs_pkg::PROD_W'(asq) << (2 * sugs_pkg::FRAC_BITS + 2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      s_q    <= s;
      calc_q <= inroi_q && (s != '0) && ({1'b0, s} >= thr_q);
      qx_q   <= '0;
      qy_q   <= '0;
      bit_q  <= sugs_pkg::BIT_W'(sugs_pkg::FRAC_BITS);
      comp_q <= 1'b0;
    end
    if (cmd_i.bit_sq) begin
      osq_q <= o * o;
      tok_q <= t <= (sugs_pkg::T_W'(1) << sugs_pkg::FRAC_BITS);
    end
    if (cmd_i.bit_mul) begin
      prod_q <= osq_q * s_q;
    end
    if (cmd_i.bit_cmp) begin
      if (tok_q && (prod_q <= rhs)) begin
        if (comp_q) begin
          qy_q <= t;
        end else begin
          qx_q <= t;
        end
      end
      if (bit_q == '0) begin
        comp_q <= 1'b1;
        bit_q  <= sugs_pkg::BIT_W'(sugs_pkg::FRAC_BITS);
      end else begin
        bit_q <= bit_q - 1'b1;
      end
    end
  end

  // result register
  logic [sugs_pkg::UNIT_W-1:0] mx, my;
  logic                        res_valid_q;

  assign mx = qx_q[sugs_pkg::UNIT_W-1:0];
  assign my = qy_q[sugs_pkg::UNIT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      unit_gx_o    <= gx_q[GW-1] ? -mx : mx;
      unit_gy_o    <= gy_q[GW-1] ? -my : my;
      out_row_o    <= y_q;
      out_col_o    <= x_q;
      frame_last_o <= last_q;
    end
  end

  assign res_valid_o = res_valid_q;

  always_comb begin
    status_o.has_result = has_res;
    status_o.calc       = calc_q;
    status_o.last_bit   = (bit_q == '0);
    status_o.last_comp  = comp_q;
    status_o.out_free   = !res_valid_q || res_ready_i;
  end

endmodule

FILE: rtl/sobel_unit_gradient_suppress.sv
// Top level of the Sobel unit-gradient block.
// Joins controller and datapath. Depends on sugs_pkg, sugs_if, sugs_ctrl, sugs_dp.
//
// Usage:
//   pix_i takes one grey pixel per request in raster order; res_o gives one
//   result per interior centre (unit_gx, unit_gy in Q1.14, centre row and
//   column, frame_last on the last centre of the frame). Border pixels give
//   no result. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i
//   while the block is idle.
//   A pixel is processed one at a time. A border pixel returns to idle after
//   the gradient step before the next request is taken. A centre inside the
//   region and above threshold goes through accept, gradient, squares and
//   threshold, then a square, multiply and compare step per quotient bit over
//   15 bits for each of gx and gy on the single shared square/multiply/compare
//   unit, and then loads the result register. A suppressed or outside centre
//   skips the root. The result appears in the cycle after the load.
//   The result register holds while res_o.ready is low; a new pixel is taken
//   meanwhile, and the block waits only when the next result must be loaded.
//   Reset clears counters, window, result valid and restores default
//   registers; line stores need no clearing.
module sobel_unit_gradient_suppress (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sugs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sugs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sugs_pix_if.sink                        pix_i,
  sugs_res_if.source                      res_o
);

  sugs_pkg::cmd_t    cmd;
  sugs_pkg::status_t status;

  sugs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (pix_i.ready)
  );

  sugs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_i      (pix_i.pixel),
    .cmd_i        (cmd),
    .status_o     (status),
    .res_ready_i  (res_o.ready),
    .res_valid_o  (res_o.valid),
    .unit_gx_o    (res_o.unit_gx),
    .unit_gy_o    (res_o.unit_gy),
    .out_row_o    (res_o.out_row),
    .out_col_o    (res_o.out_col),
    .frame_last_o (res_o.frame_last)
  );

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!res_o.valid || res_o.ready))
    else $error("result loaded over a pending one");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> res_o.valid)
    else $error("loaded result not presented");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ($signed(res_o.unit_gx) <= 16384 && $signed(res_o.unit_gx) >= -16384
                  && $signed(res_o.unit_gy) <= 16384 && $signed(res_o.unit_gy) >= -16384))
    else $error("unit gradient out of range");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> !pix_i.ready)
    else $error("second pixel request taken during processing");

endmodule

FILE: verif/sobel_unit_gradient_suppress_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sobel_unit_gradient_suppress: pixel frames in raster order,
// results checked field by field against an in-bench unit-gradient predictor.
// Depends on sugs_pkg, sugs_if and the block's RTL.
module sobel_unit_gradient_suppress_tb;

  typedef struct packed {
    logic [sugs_pkg::UNIT_W-1:0]    gx;
    logic [sugs_pkg::UNIT_W-1:0]    gy;
    logic [sugs_pkg::OUT_ROW_W-1:0] row;
    logic [sugs_pkg::OUT_COL_W-1:0] col;
    logic                           last;
  } grad_res_t;

  typedef struct {
    logic [sugs_pkg::PIX_W-1:0] pix;
    bit                         typed;
    grad_res_t                  res;
  } pix_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [sugs_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [sugs_pkg::CFG_DATA_W-1:0] cfg_data_i;

  sugs_pix_if pix ();
  sugs_res_if res ();

  sobel_unit_gradient_suppress uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .res_o      (res)
  );

  int img_w, img_h, roi_x, roi_y, roi_w, roi_h, min_con;
  logic [sugs_pkg::PIX_W-1:0] row_up [sugs_pkg::MAX_WIDTH];
  logic [sugs_pkg::PIX_W-1:0] row_up2 [sugs_pkg::MAX_WIDTH];
  logic [sugs_pkg::PIX_W-1:0] win [6];
  int cur_row, cur_col;

  grad_res_t grad_q[$];
  pix_row_t  tag_q[$];
  bit        typed_ok;
  grad_res_t typed_val;
  int errors, pixels_sent, results_seen, frames_done;
  int burst_left;
  int hold_len, hold_seq, hold_seen, hold_cnt;
  int unsigned cyc;
  pix_row_t dir_tab[$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("sobel_unit_gradient_suppress: mismatch");
    $finish;
  end

  function automatic logic [sugs_pkg::UNIT_W-1:0] unit_q14(int g, longint unsigned s);
    longint unsigned a, rhs, lim, q, t, o;
    int b;
    a   = (g < 0) ? -g : g;
    rhs = (4 * a * a) << (2 * sugs_pkg::FRAC_BITS);
    lim = 64'd1 << sugs_pkg::FRAC_BITS;
    q   = 0;
    for (b = sugs_pkg::FRAC_BITS; b >= 0; b--) begin
      t = q | (64'd1 << b);
      o = 2 * t - 1;
      if (t <= lim && o * o * s <= rhs) q = t;
    end
    if (g < 0) q = -q;
    return q[sugs_pkg::UNIT_W-1:0];
  endfunction

  function automatic void predict_pixel(logic [sugs_pkg::PIX_W-1:0] p, bit tk, grad_res_t tv);
    int w, h, r, c, gx, gy, y, x, rb, cb, re, ce;
    longint unsigned s, thr;
    logic [sugs_pkg::PIX_W-1:0] top, mid;
    grad_res_t e;
    w = (img_w == 0) ? 1 : ((img_w > sugs_pkg::MAX_WIDTH) ? sugs_pkg::MAX_WIDTH : img_w);
    h = (img_h == 0) ? 1 : ((img_h > sugs_pkg::MAX_HEIGHT) ? sugs_pkg::MAX_HEIGHT : img_h);
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    r = cur_row;
    c = cur_col;
    top = row_up2[c];
    mid = row_up[c];
    if (w >= 3 && h >= 3 && r >= 2 && c >= 2) begin
      gx = (int'(top) - int'(win[0])) + 2 * (int'(mid) - int'(win[2]))
         + (int'(p) - int'(win[4]));
      gy = (int'(win[4]) - int'(win[0])) + 2 * (int'(win[5]) - int'(win[1]))
         + (int'(p) - int'(top));
      y = r - 1;
      x = c - 1;
      rb = (roi_y > 1) ? roi_y : 1;
      cb = (roi_x > 1) ? roi_x : 1;
      re = roi_y + roi_h;
      ce = roi_x + roi_w;
      if (re > h - 1) re = h - 1;
      if (ce > w - 1) ce = w - 1;
      s = longint'(gx) * gx + longint'(gy) * gy;
      thr = longint'(min_con) * min_con * 64;
      e.gx = '0;
      e.gy = '0;
      if (y >= rb && y < re && x >= cb && x < ce && s != 0 && s >= thr) begin
        e.gx = unit_q14(gx, s);
        e.gy = unit_q14(gy, s);
      end
      e.row  = sugs_pkg::OUT_ROW_W'(y);
      e.col  = sugs_pkg::OUT_COL_W'(x);
      e.last = (r == h - 1 && c == w - 1);
      grad_q.push_back(tk ? tv : e);
    end
    win[0] = win[1]; win[1] = top;
    win[2] = win[3]; win[3] = mid;
    win[4] = win[5]; win[5] = p;
    row_up2[c] = mid;
    row_up[c]  = p;
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= h) cur_row = 0;
    end
  endfunction

  always @(posedge clk_i) begin
    grad_res_t e;
    pix_row_t  tag;
    if (rst_ni) begin
      if (pix.valid && pix.ready) begin
        tag = tag_q.pop_front();
        predict_pixel(pix.pixel, tag.typed, tag.res);
      end
      if (res.valid && res.ready) begin
        results_seen++;
        if (grad_q.size() == 0) begin
          $display("%0t: unexpected result gx=%h gy=%h row=%0d col=%0d last=%b", $realtime,
                   res.unit_gx, res.unit_gy, res.out_row, res.out_col, res.frame_last);
          errors++;
        end else begin
          e = grad_q.pop_front();
          if (res.unit_gx !== e.gx) begin
            $display("%0t: unit_gx exp %h act %h", $realtime, e.gx, res.unit_gx);
            errors++;
          end
          if (res.unit_gy !== e.gy) begin
            $display("%0t: unit_gy exp %h act %h", $realtime, e.gy, res.unit_gy);
            errors++;
          end
          if (res.out_row !== e.row) begin
            $display("%0t: out_row exp %0d act %0d", $realtime, e.row, res.out_row);
            errors++;
          end
          if (res.out_col !== e.col) begin
            $display("%0t: out_col exp %0d act %0d", $realtime, e.col, res.out_col);
            errors++;
          end
          if (res.frame_last !== e.last) begin
            $display("%0t: frame_last exp %b act %b", $realtime, e.last, res.frame_last);
            errors++;
          end
        end
      end
    end
  end

  // hold off on request, else stall on a rotating pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
      cyc <= 0;
      hold_seen <= 0;
      hold_cnt <= 0;
    end else begin
      cyc <= cyc + 1;
      if (hold_seen != hold_seq) begin
        hold_seen <= hold_seq;
        hold_cnt <= hold_len;
        res.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        res.ready <= 1'b0;
      end else begin
        case ((cyc / 700) % 3)
          0: res.ready <= 1'b1;
          1: res.ready <= (cyc % 5 != 0) && (cyc % 7 != 3);
          default: res.ready <= cyc[2] ^ cyc[5];
        endcase
      end
    end
  end

  task automatic start_hold(int n);
    hold_len = n;
    hold_seq++;
  endtask

  task automatic send_pixel(logic [sugs_pkg::PIX_W-1:0] p);
    int gap;
    pix_row_t tag;
    tag.pix = p;
    tag.typed = typed_ok;
    tag.res = typed_val;
    tag_q.push_back(tag);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    pix.valid <= 1'b1;
    pix.pixel <= p;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (grad_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(int w, int h, int rx, int ry, int rw, int rh, int mc);
    int v [7];
    int i;
    v = '{w, h, rx, ry, rw, rh, mc};
    drain();
    repeat (200) @(posedge clk_i);
    for (i = 0; i < 7; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= sugs_pkg::CFG_IDX_W'(i);
      cfg_data_i <= sugs_pkg::CFG_DATA_W'(v[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    img_w = w & 12'hFFF;
    img_h = h & 13'h1FFF;
    roi_x = rx & 11'h7FF;
    roi_y = ry & 12'hFFF;
    roi_w = rw & 12'hFFF;
    roi_h = rh & 13'h1FFF;
    min_con = mc & 8'hFF;
  endtask

  task automatic send_frame(int w, int h, int mode, bit mid_drain);
    int ew, eh, i, total;
    logic [sugs_pkg::PIX_W-1:0] p;
    ew = (w == 0) ? 1 : w;
    eh = (h == 0) ? 1 : h;
    total = ew * eh;
    for (i = 0; i < total; i++) begin
      case (mode)
        0: p = sugs_pkg::PIX_W'($urandom_range(0, 255));
        1: p = sugs_pkg::PIX_W'((i % ew) * 23 + (i / ew) * 11 + $urandom_range(0, 6));
        2: p = 8'h5A;
        default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      send_pixel(p);
      if (mid_drain && i == total / 2) drain();
    end
    frames_done++;
  endtask

  task automatic add_row(logic [sugs_pkg::PIX_W-1:0] p, bit t, grad_res_t r);
    pix_row_t x;
    x.pix = p;
    x.typed = t;
    x.res = r;
    dir_tab.push_back(x);
  endtask

  initial begin
    int i, w, h;
    grad_res_t none;
    none = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = sugs_pkg::CFG_IMAGE_WIDTH;
    cfg_data_i = '0;
    pix.valid = 1'b0;
    pix.pixel = '0;
    typed_ok = 1'b0;
    typed_val = '0;
    hold_len = 0;
    hold_seq = 0;
    burst_left = 0;
    img_w = 640; img_h = 480; roi_x = 0; roi_y = 0; roi_w = 2048; roi_h = 4096; min_con = 0;
    cur_row = 0; cur_col = 0;
    foreach (win[k]) win[k] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // flat, right-bright edge, top-bright edge on a 3x3 frame
    for (i = 0; i < 8; i++) add_row(8'h80, 1'b0, none);
    add_row(8'h80, 1'b1, '{16'h0000, 16'h0000, 12'd1, 11'd1, 1'b1});
    for (i = 0; i < 8; i++) add_row((i % 3 == 0) ? 8'h00 : ((i % 3 == 1) ? 8'h80 : 8'hFF),
                                    1'b0, none);
    add_row(8'hFF, 1'b1, '{16'h4000, 16'h0000, 12'd1, 11'd1, 1'b1});
    for (i = 0; i < 8; i++) add_row((i < 3) ? 8'hFF : ((i < 6) ? 8'h09 : 8'h00), 1'b0, none);
    add_row(8'h00, 1'b1, '{16'h0000, 16'hC000, 12'd1, 11'd1, 1'b1});

    write_regs(3, 3, 0, 0, 2048, 4096, 0);
    foreach (dir_tab[k]) begin
      typed_ok  = dir_tab[k].typed;
      typed_val = dir_tab[k].res;
      send_pixel(dir_tab[k].pix);
      typed_ok = 1'b0;
    end

    // register extremes: ROI out of reach, full contrast, oversized and tiny frames
    write_regs(6, 5, 2047, 4095, 0, 0, 255);
    send_frame(6, 5, 0, 1'b0);
    write_regs(5, 4, 0, 0, 2048, 4096, 255);
    send_frame(5, 4, 3, 1'b0);
    // partial first row of a capped frame, then realign with a one-pixel frame
    write_regs(4095, 8191, 0, 0, 2048, 4096, 0);
    for (i = 0; i < 24; i++) send_pixel(sugs_pkg::PIX_W'($urandom_range(0, 255)));
    write_regs(0, 0, 3, 2, 1, 1, 0);
    send_frame(0, 0, 0, 1'b0);
    write_regs(2, 4, 0, 0, 4, 4, 1);
    send_frame(2, 4, 0, 1'b0);

    write_regs(10, 6, 0, 0, 2048, 4096, 0);
    start_hold(600);
    send_frame(10, 6, 0, 1'b1);

    while (pixels_sent < 850) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(1, 2);
        h = $urandom_range(1, 6);
      end else begin
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 8);
      end
      if ($urandom_range(0, 3) == 0)
        write_regs(w, h, $urandom_range(0, 2047), $urandom_range(0, 4095),
                   $urandom_range(0, 2048), $urandom_range(0, 4096), $urandom_range(0, 255));
      else
        write_regs(w, h, $urandom_range(0, w), $urandom_range(0, h), $urandom_range(0, w),
                   $urandom_range(0, h), ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 60));
      if ($urandom_range(0, 15) == 0) start_hold($urandom_range(50, 400));
      send_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 19) == 0);
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (grad_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, grad_q.size());
      errors++;
    end
    $display("Covered %0d frames, %0d pixel requests, %0d results, %0d errors.",
             frames_done, pixels_sent, results_seen, errors);
    if (errors == 0) begin
      $display("sobel_unit_gradient_suppress: match");
    end else begin
      $display("sobel_unit_gradient_suppress: mismatch");
    end
    $finish;
  end

endmodule
